/* design/pce_pkg.sv */
`default_nettype none

package pce_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int INDEX_BITS  = 6;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    // Field widths of the channels
    localparam int VALUE_BITS  = 6;
    localparam int ELEM_BITS   = 6;

    // Results per run
    localparam int MAX_RESULTS = 64;
    localparam int RES_BITS    = $clog2(MAX_RESULTS);

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Command from the walk engine to the output stage
    typedef struct packed {
        logic                  push;
        logic                  fin;
        logic [INDEX_BITS-1:0] elem;
        logic                  lp;
    } emit_t;

endpackage

`default_nettype wire

/* design/pce_if.sv */
`default_nettype none

interface pce_req_if import pce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [VALUE_BITS-1:0] entry_value;
    logic                  entry_defined;

    modport source (output valid, kind, entry_value, entry_defined, input ready);
    modport sink   (input valid, kind, entry_value, entry_defined, output ready);
endinterface

interface pce_rsp_if import pce_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] element;
    logic                 last_of_piece;
    logic                 last_of_run;
    logic                 empty_run;

    modport source (output valid, element, last_of_piece, last_of_run, empty_run,
                    input ready);
    modport sink   (input valid, element, last_of_piece, last_of_run, empty_run,
                    output ready);
endinterface

`default_nettype wire

/* design/permutation_cycle_extractor.sv */
`default_nettype none

// Load items are accepted back to back; they return nothing. A run first issues the
// first image memory read, then scans indices and emits elements, one read of the
// image memory each and only while the output stage has room, then releases the
// final item. Reset clears the fill count and all control state; the image memory
// is not cleared.
module permutation_cycle_extractor import pce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pce_req_if.sink   req,
    pce_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_WALK = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [INDEX_BITS-1:0]  cur_reg, cur_next;
    logic [INDEX_BITS-1:0]  root_reg, root_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic [RES_BITS-1:0]    res_reg, res_next;

    // Image memory: defined flag above the image value
    logic [INDEX_BITS:0]    mem [TABLE_DEPTH];
    logic [INDEX_BITS:0]    rdata_reg;
    logic                   mem_we;

    emit_t                  cmd;
    logic                   go;

    logic                   ent_def;
    logic [INDEX_BITS-1:0]  ent_val;
    logic                   ent_ok;
    logic                   ent_cont;
    logic                   at_cap;
    logic                   piece_end;
    logic [CNT_BITS-1:0]    cur_inc;
    logic [CNT_BITS-1:0]    root_inc;

    pce_out_stage u_out
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .free  (go),
        .rsp   (rsp)
    );

    assign ent_def  = rdata_reg[INDEX_BITS];
    assign ent_val  = rdata_reg[INDEX_BITS-1:0];
    // Entry still open: defined, in range and not yet consumed this run
    assign ent_ok   = ent_def && (CNT_BITS'(ent_val) < count_reg) && !used_reg[cur_reg];
    assign ent_cont = ent_ok && (ent_val != cur_reg);
    assign at_cap   = (res_reg == RES_BITS'(MAX_RESULTS - 1));
    assign cur_inc  = CNT_BITS'(cur_reg) + CNT_BITS'(1);
    assign root_inc = CNT_BITS'(root_reg) + CNT_BITS'(1);
    assign piece_end = !ent_cont || (ent_val == root_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign mem_we    = req.valid && req.ready && (req.kind == KIND_LOAD)
                       && (count_reg < CNT_BITS'(TABLE_DEPTH));

    // Sequence the scan and the walks
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        root_next  = root_reg;
        used_next  = used_reg;
        res_next   = res_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.kind == KIND_LOAD)
                    begin
                        if (mem_we)
                        begin
                            count_next = count_reg + CNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        used_next = '0;
                        res_next  = '0;
                        cur_next  = '0;
                        if (count_reg == '0)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (go)
                begin
                    if (ent_cont)
                    begin
                        // Open a piece at this index
                        cmd.push          = 1'b1;
                        cmd.elem          = cur_reg;
                        cmd.lp            = at_cap;
                        used_next[cur_reg] = 1'b1;
                        res_next          = res_reg + RES_BITS'(1);
                        root_next         = cur_reg;
                        if (at_cap)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            cur_next   = ent_val;
                            state_next = ST_WALK;
                        end
                    end
                    else if (cur_inc == count_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cur_next = cur_inc[INDEX_BITS-1:0];
                    end
                end
            end

            ST_WALK:
            begin
                if (go)
                begin
                    // Emit this element and follow its image unless the piece or the run ends here
                    cmd.push          = 1'b1;
                    cmd.elem          = cur_reg;
                    cmd.lp            = piece_end || at_cap;
                    used_next[cur_reg] = 1'b1;
                    res_next          = res_reg + RES_BITS'(1);
                    if (at_cap)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (piece_end)
                    begin
                        if (root_inc == count_reg)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            cur_next   = root_inc[INDEX_BITS-1:0];
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        cur_next = ent_val;
                    end
                end
            end

            ST_FIN:
            begin
                if (go)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cur_reg   <= '0;
            root_reg  <= '0;
            used_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            root_reg  <= root_next;
            used_reg  <= used_next;
            res_reg   <= res_next;
        end
    end

    // Write loads in order; read the entry the engine visits next
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[INDEX_BITS-1:0]] <= {req.entry_defined,
                                               req.entry_value[INDEX_BITS-1:0]};
        end
        rdata_reg <= mem[cur_next];
    end

    // Engine only visits loaded entries
    a_cur_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_WALK)
        |-> (CNT_BITS'(cur_reg) < count_reg))
        else $error("visited index beyond the loaded table");

    // The piece start is consumed for the whole walk
    a_root_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> used_reg[root_reg])
        else $error("walk root not marked consumed");

    // No results leave the engine while it waits for items
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(cmd.push || cmd.fin))
        else $error("result issued while idle");

    // Loads never run the fill count past the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

endmodule

`default_nettype wire

/* design/pce_out_stage.sv */
`default_nettype none

module pce_out_stage import pce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_t      cmd,
    output logic       free,
    pce_rsp_if.source  rsp
);

    logic                  pend_valid_reg, pend_valid_next;
    logic [INDEX_BITS-1:0] pend_elem_reg, pend_elem_next;
    logic                  pend_lp_reg, pend_lp_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ELEM_BITS-1:0]  out_elem_reg, out_elem_next;
    logic                  out_lp_reg, out_lp_next;
    logic                  out_lr_reg, out_lr_next;
    logic                  out_empty_reg, out_empty_next;

    // The output register can take a new item this cycle
    assign free = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.element       = out_elem_reg;
    assign rsp.last_of_piece = out_lp_reg;
    assign rsp.last_of_run   = out_lr_reg;
    assign rsp.empty_run     = out_empty_reg;

    // Hold one result back until it is known whether it ends the run
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_elem_next  = pend_elem_reg;
        pend_lp_next    = pend_lp_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_elem_next   = out_elem_reg;
        out_lp_next     = out_lp_reg;
        out_lr_next     = out_lr_reg;
        out_empty_next  = out_empty_reg;

        if (cmd.push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_elem_next  = ELEM_BITS'(pend_elem_reg);
                out_lp_next    = pend_lp_reg;
                out_lr_next    = 1'b0;
                out_empty_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_elem_next  = cmd.elem;
            pend_lp_next    = cmd.lp;
        end
        else if (cmd.fin)
        begin
            out_valid_next = 1'b1;
            out_lr_next    = 1'b1;
            if (pend_valid_reg)
            begin
                out_elem_next  = ELEM_BITS'(pend_elem_reg);
                out_lp_next    = 1'b1;
                out_empty_next = 1'b0;
            end
            else
            begin
                out_elem_next  = '0;
                out_lp_next    = 1'b0;
                out_empty_next = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_elem_reg <= pend_elem_next;
        pend_lp_reg   <= pend_lp_next;
        out_elem_reg  <= out_elem_next;
        out_lp_reg    <= out_lp_next;
        out_lr_reg    <= out_lr_next;
        out_empty_reg <= out_empty_next;
    end

    // Engine never issues two commands at once
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.fin))
        else $error("push and finish in the same cycle");

    // Engine only issues a command when the output register has room
    a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push || cmd.fin) |-> free)
        else $error("command issued while output stalled");

    // Finishing a run leaves nothing held back
    a_fin_drains: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> (!pend_valid_reg && out_valid_reg && out_lr_reg))
        else $error("run end did not drain the held result");

    // An empty-run marker is the only item of its run
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_lr_reg && !out_lp_reg))
        else $error("malformed empty-run item");

endmodule

`default_nettype wire

/* tb/sv/pce_cycle_checker.sv */
`timescale 1ns / 1ps

module pce_cycle_checker import pce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pce_req_if   req,
    pce_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   checked_count,
    output int   capped_runs,
    output int   empty_runs
);

    typedef struct packed {
        logic [ELEM_BITS-1:0] element;
        logic                 piece_end;
        logic                 run_end;
        logic                 empty;
    } elem_rec_t;

    // Shadow copy of the mapping table
    logic [INDEX_BITS-1:0] image_copy   [TABLE_DEPTH];
    bit                    defined_copy [TABLE_DEPTH];
    int                    fill;

    // Result items still owed by the block, oldest first
    elem_rec_t             expected_elems [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Append one expectation behind the ones already owed
    task automatic queue_expected(input elem_rec_t r);
        expected_elems.insert(expected_elems.size(), r);
    endtask

    function automatic elem_rec_t elem_of(input int e);
        elem_rec_t r;
        r.element   = ELEM_BITS'(e);
        r.piece_end = 1'b0;
        r.run_end   = 1'b0;
        r.empty     = 1'b0;
        return r;
    endfunction

    // Split the loaded map into pieces and queue one item per emitted element, or one empty-run item if there is none
    task automatic predict_pieces();
        bit        unvisited [TABLE_DEPTH];
        elem_rec_t res [MAX_RESULTS];
        elem_rec_t none;
        int        cnt;
        int        x;
        int        z;
        int        nz;
        bit        stop;
        cnt  = 0;
        stop = 1'b0;
        for (x = 0; x < TABLE_DEPTH; x++)
            unvisited[x] = (x < fill) && defined_copy[x] && (int'(image_copy[x]) < fill);

        for (x = 0; x < fill && !stop; x++)
        begin
            if (unvisited[x])
            begin
                if (int'(image_copy[x]) == x)
                    unvisited[x] = 1'b0;
                else if (cnt >= MAX_RESULTS)
                    stop = 1'b1;
                else
                begin
                    res[cnt] = elem_of(x);
                    cnt++;
                    z = int'(image_copy[x]);
                    // Follow images until the walk closes, runs into a dead end or hits the result limit
                    while (z != x && !stop)
                    begin
                        if (cnt >= MAX_RESULTS)
                            stop = 1'b1;
                        else
                        begin
                            res[cnt] = elem_of(z);
                            cnt++;
                            if (unvisited[z] && int'(image_copy[z]) != z)
                            begin
                                nz           = int'(image_copy[z]);
                                unvisited[z] = 1'b0;
                                z            = nz;
                            end
                            else
                            begin
                                unvisited[z] = 1'b0;
                                z            = x;
                            end
                        end
                    end
                    if (!stop)
                    begin
                        res[cnt-1].piece_end = 1'b1;
                        unvisited[x]         = 1'b0;
                    end
                end
            end
        end

        if (cnt == 0)
        begin
            none         = elem_of(0);
            none.run_end = 1'b1;
            none.empty   = 1'b1;
            queue_expected(none);
            empty_runs++;
        end
        else
        begin
            res[cnt-1].piece_end = 1'b1;
            res[cnt-1].run_end   = 1'b1;
            if (stop)
                capped_runs++;
            for (x = 0; x < cnt; x++)
                queue_expected(res[x]);
        end
    endtask

    // Compare one accepted result item with the oldest expectation
    task automatic check_result();
        elem_rec_t want;
        if (expected_elems.size() == 0)
            report_mismatch($sformatf("unexpected result item, element %0d", rsp.element));
        else
        begin
            want = expected_elems.pop_front();
            checked_count++;
            if (rsp.element !== want.element)
                report_mismatch($sformatf("element got %0d, expected %0d",
                                          rsp.element, want.element));
            if (rsp.last_of_piece !== want.piece_end)
                report_mismatch($sformatf("last_of_piece got %b, expected %b (element %0d)",
                                          rsp.last_of_piece, want.piece_end, want.element));
            if (rsp.last_of_run !== want.run_end)
                report_mismatch($sformatf("last_of_run got %b, expected %b (element %0d)",
                                          rsp.last_of_run, want.run_end, want.element));
            if (rsp.empty_run !== want.empty)
                report_mismatch($sformatf("empty_run got %b, expected %b (element %0d)",
                                          rsp.empty_run, want.empty, want.element));
        end
    endtask

    // Watch both channels: check results, then advance the shadow table or predict a run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill          = 0;
            fail_count    = 0;
            checked_count = 0;
            capped_runs   = 0;
            empty_runs    = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                image_copy[i]   = '0;
                defined_copy[i] = 1'b0;
            end
            expected_elems.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_result();
            if (req.valid && req.ready)
            begin
                if (req.kind == KIND_LOAD)
                begin
                    // Drop loads once the table is full
                    if (fill < TABLE_DEPTH)
                    begin
                        image_copy[fill]   = req.entry_value[INDEX_BITS-1:0];
                        defined_copy[fill] = req.entry_defined;
                        fill++;
                    end
                end
                else
                    predict_pieces();
            end
            pending = expected_elems.size();
        end
    end

endmodule

/* tb/sv/tb_permutation_cycle_extractor.sv */
`timescale 1ns / 1ps

module tb_permutation_cycle_extractor import pce_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int TAIL_ITEMS     = 60;

    logic clk;
    logic rst_n;

    pce_req_if req_ch ();
    pce_rsp_if rsp_ch ();

    int   fail_count;
    int   pending;
    int   checked_count;
    int   capped_runs;
    int   empty_runs;

    logic req_fire;
    logic rsp_fire;
    int   idle_cycles;

    int   loads_sent;
    int   runs_sent;
    int   table_fill;
    bit   snd_quiet;
    bit   rcv_quiet;

    permutation_cycle_extractor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pce_cycle_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .capped_runs   (capped_runs),
        .empty_runs    (empty_runs)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Register handshakes and count cycles without any accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_fire    <= 1'b0;
            rsp_fire    <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            rsp_fire <= rsp_ch.valid && rsp_ch.ready;
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog: no item accepted for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each item
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rcv_quiet = !rcv_quiet;
            stall = rcv_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(negedge clk); while (!rsp_fire);
        end
    end

    // Offer one item after a random gap; optionally hold until all results are in
    task automatic send_item(input logic item_kind, input logic [VALUE_BITS-1:0] value,
                             input logic defined, input bit drain);
        int gap;
        if ($urandom_range(0, 15) == 0)
            snd_quiet = !snd_quiet;
        gap = snd_quiet ? 0 : $urandom_range(0, 8);
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            while (drain && pending != 0)
                @(negedge clk);
        end
        req_ch.kind          <= item_kind;
        req_ch.entry_value   <= value;
        req_ch.entry_defined <= defined;
        req_ch.valid         <= 1'b1;
        do @(negedge clk); while (!req_fire);
        if (item_kind == KIND_LOAD)
        begin
            loads_sent++;
            if (table_fill < TABLE_DEPTH)
                table_fill++;
        end
        else
            runs_sent++;
    endtask

    // Image for the entry at idx: mostly back links, forward chains and fixed points
    function automatic logic [VALUE_BITS-1:0] pick_image(input int idx);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4 && idx > 0)
            v = $urandom_range(0, idx - 1);
        else if (sel < 7)
            v = idx + 1 + $urandom_range(0, 6);
        else if (sel < 8)
            v = idx;
        else
            v = $urandom_range(0, 63);
        if (v > 63)
            v = $urandom_range(0, 63);
        return VALUE_BITS'(v);
    endfunction

    initial
    begin
        int tail;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_LOAD;
        req_ch.entry_value   = '0;
        req_ch.entry_defined = 1'b0;
        loads_sent           = 0;
        runs_sent            = 0;
        table_fill           = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table, then a lone fixed point
        send_item(KIND_RUN,  6'd0,  1'b0, 1'b0);
        send_item(KIND_LOAD, 6'd0,  1'b1, 1'b0);
        send_item(KIND_RUN,  6'd63, 1'b1, 1'b0);
        // Image beyond the table, then an undefined entry
        send_item(KIND_LOAD, 6'd63, 1'b1, 1'b0);
        send_item(KIND_LOAD, 6'd1,  1'b0, 1'b0);
        send_item(KIND_RUN,  6'd0,  1'b0, 1'b0);
        // Index 3 points past the table until index 4 closes a swap with it
        send_item(KIND_LOAD, 6'd4,  1'b1, 1'b0);
        send_item(KIND_RUN,  6'd21, 1'b0, 1'b0);
        send_item(KIND_LOAD, 6'd3,  1'b1, 1'b0);
        send_item(KIND_RUN,  6'd42, 1'b1, 1'b0);
        // Chains that end on a fixed point and on an element already consumed
        send_item(KIND_LOAD, 6'd0,  1'b1, 1'b0);
        send_item(KIND_LOAD, 6'd3,  1'b1, 1'b0);
        send_item(KIND_RUN,  6'd0,  1'b0, 1'b0);
        // Links into later indices and onto an out-of-range entry
        send_item(KIND_LOAD, 6'd42, 1'b1, 1'b0);
        send_item(KIND_LOAD, 6'd21, 1'b1, 1'b0);
        send_item(KIND_LOAD, 6'd1,  1'b1, 1'b0);
        send_item(KIND_RUN,  6'd63, 1'b0, 1'b1);

        // Fill the rest of the table with random links, runs in between
        while (table_fill < TABLE_DEPTH)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(KIND_RUN, VALUE_BITS'($urandom), 1'($urandom),
                          $urandom_range(0, 19) == 0);
            else
                send_item(KIND_LOAD, pick_image(table_fill), $urandom_range(0, 7) != 0,
                          $urandom_range(0, 19) == 0);
        end

        // Full table: runs mixed with loads that must be dropped
        for (tail = 0; tail < TAIL_ITEMS; tail++)
        begin
            if ($urandom_range(0, 2) != 0)
                send_item(KIND_RUN, VALUE_BITS'($urandom), 1'($urandom),
                          $urandom_range(0, 19) == 0);
            else
                send_item(KIND_LOAD, VALUE_BITS'($urandom), 1'($urandom), 1'b0);
        end
        req_ch.valid <= 1'b0;

        // Wait for the last results, then let the block settle
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d load items (%0d stored) and %0d run items; %0d result items checked",
                 loads_sent, table_fill, runs_sent, checked_count);
        $display("%0d runs were cut at the result limit, %0d runs found no piece",
                 capped_runs, empty_runs);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
